// File: hdl/pfn_pkg.sv
// Package for the fBm gradient noise block: sequencer state codes and register indexes.
// No dependencies.
package pfn_pkg;

    localparam int STATE_W = 4;

    localparam logic [STATE_W-1:0] ST_INIT = 4'd0;
    localparam logic [STATE_W-1:0] ST_SHUF = 4'd1;
    localparam logic [STATE_W-1:0] ST_BDIV = 4'd2;
    localparam logic [STATE_W-1:0] ST_SW0  = 4'd3;
    localparam logic [STATE_W-1:0] ST_SW1  = 4'd4;
    localparam logic [STATE_W-1:0] ST_SW2  = 4'd5;
    localparam logic [STATE_W-1:0] ST_SW3  = 4'd6;
    localparam logic [STATE_W-1:0] ST_SW4  = 4'd7;
    localparam logic [STATE_W-1:0] ST_IDLE = 4'd8;
    localparam logic [STATE_W-1:0] ST_OCT  = 4'd9;
    localparam logic [STATE_W-1:0] ST_FIN  = 4'd10;
    localparam logic [STATE_W-1:0] ST_NDIV = 4'd11;
    localparam logic [STATE_W-1:0] ST_DONE = 4'd12;

    localparam logic REG_SEED    = 1'b0;
    localparam logic REG_OCTAVES = 1'b1;

    typedef logic [3:0] oct_cfg_t;

endpackage

// File: hdl/pfn_if.sv
// Valid/ready channel interfaces for sample points and noise results.
// No dependencies.
interface pfn_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pfn_noise_if #(parameter int W = 17);
    logic         valid;
    logic         ready;
    logic [W-1:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// File: hdl/perlin_fbm_noise_2d.sv
// Top level: 2D fBm gradient noise with a seeded permutation table in block RAM.
// Depends on pfn_pkg and the channel interfaces in pfn_if.sv.
// Handles one transaction at a time: a new point is taken only in the idle state.
// The octave loop is set by the single table read port and the one shared multiplier;
//   the final normalising division runs one quotient bit per cycle.
// Reset (asynchronous, active low): seed 1, octave count 4, then the table build
//   with point.ready low. Every seed write starts the same build again.
module perlin_fbm_noise_2d
    import pfn_pkg::*;
#(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    pfn_point_if.sink         point,
    pfn_noise_if.source       noise,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [31:0]       wr_data
);

    // widths
    localparam int IW   = $clog2(TABLE_SIZE);          // table index and entry
    localparam int OW   = $clog2(MAX_OCTAVES + 1);     // octave count
    localparam int EW   = 32 + MAX_OCTAVES + IW;       // scaled coordinate
    localparam int MW   = FRAC_BITS + 5;               // multiplier operand
    localparam int GW   = FRAC_BITS + 3;               // gradient / lerp value
    localparam int SW   = FRAC_BITS + MAX_OCTAVES + 3; // octave sum
    localparam int DW   = (SW > 32) ? SW : 32;         // divider dividend
    localparam int DENW = (IW + 1 > MAX_OCTAVES + 1) ? IW + 1 : MAX_OCTAVES + 1;
    localparam int RW   = DENW + 1;
    localparam int CW   = $clog2(DW + 1);

    localparam logic signed [MW-1:0] FIFTEEN_ONE = MW'(15) <<< FRAC_BITS;
    localparam logic signed [MW-1:0] TEN_ONE     = MW'(10) <<< FRAC_BITS;
    localparam logic signed [MW-1:0] SIX         = MW'(6);
    localparam logic signed [GW-1:0] ONE_G       = GW'(1) <<< FRAC_BITS;
    localparam logic [DW-1:0]        ONE_Q       = DW'(1) << FRAC_BITS;
    localparam logic [IW-1:0]        LAST_IDX    = IW'(TABLE_SIZE - 1);

    // gradient: one of eight directions, second axis weighted by two
    function automatic logic signed [GW-1:0] grad(input logic [2:0] h,
                                                  input logic signed [GW-1:0] gx,
                                                  input logic signed [GW-1:0] gy);
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        logic signed [GW-1:0] r;
        begin
            u = h[2] ? gy : gx;
            v = h[2] ? gx : gy;
            r = h[0] ? -u : u;
            r = h[1] ? r - (v <<< 1) : r + (v <<< 1);
            return r;
        end
    endfunction

    // ---------------------------------------------------------------- registers
    logic [STATE_W-1:0]   state_reg, state_next;
    oct_cfg_t             oct_cfg_reg;
    logic [31:0]          shuf_reg;
    logic [IW-1:0]        bi_reg;          // build index
    logic [IW-1:0]        pi_reg;          // swap temp

    logic [DW-1:0]        quo_reg;
    logic [RW-1:0]        rem_reg;
    logic [DENW-1:0]      den_reg;
    logic [CW-1:0]        cnt_reg;

    logic signed [31:0]   x_reg, y_reg;
    logic [OW-1:0]        oct_reg, o_reg;
    logic [3:0]           step_reg;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [MW-1:0] rx_reg, ry_reg, fu_reg, fv_reg;
    logic [IW-1:0]        pa_reg, pb_reg;
    logic [2:0]           h00_reg, h01_reg, h10_reg, h11_reg;
    logic signed [GW-1:0] l0_reg;
    logic signed [SW-1:0] sum_reg;
    logic [FRAC_BITS:0]   res_reg;
    logic                 out_valid_reg;

    // ---------------------------------------------------------------- table memory
    logic [IW-1:0] perm_mem [TABLE_SIZE];
    logic [IW-1:0] rdata_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_wdata, mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= perm_mem[mem_raddr];
    end

    // ---------------------------------------------------------------- datapath
    logic [31:0] xs1, xs2, xs3;
    assign xs1 = shuf_reg ^ (shuf_reg << 13);
    assign xs2 = xs1 ^ (xs1 >> 17);
    assign xs3 = xs2 ^ (xs2 << 5);

    // shared restoring divider, one quotient bit per cycle
    logic [RW-1:0] rem_sh, rem_n;
    logic          div_ge;
    assign rem_sh = {rem_reg[RW-2:0], quo_reg[DW-1]};
    assign div_ge = rem_sh >= {1'b0, den_reg};
    assign rem_n  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;

    // octave coordinates: wrap at the table, fraction below
    logic signed [EW-1:0] xs, ys;
    logic [IW-1:0]        cx, cy;
    logic [FRAC_BITS-1:0] tx, ty;
    assign xs = EW'(x_reg) <<< o_reg;
    assign ys = EW'(y_reg) <<< o_reg;
    assign cx = xs[FRAC_BITS+IW-1:FRAC_BITS];
    assign cy = ys[FRAC_BITS+IW-1:FRAC_BITS];
    assign tx = xs[FRAC_BITS-1:0];
    assign ty = ys[FRAC_BITS-1:0];

    logic signed [MW-1:0] tx_m, ty_m;
    assign tx_m = $signed({{(MW-FRAC_BITS){1'b0}}, tx});
    assign ty_m = $signed({{(MW-FRAC_BITS){1'b0}}, ty});

    logic signed [GW-1:0] fxg, fyg, g00, g10, g01, g11;
    assign fxg = $signed({{(GW-FRAC_BITS){1'b0}}, tx});
    assign fyg = $signed({{(GW-FRAC_BITS){1'b0}}, ty});
    assign g00 = grad(h00_reg, fxg, fyg);
    assign g10 = grad(h10_reg, fxg - ONE_G, fyg);
    assign g01 = grad(h01_reg, fxg, fyg - ONE_G);
    assign g11 = grad(h11_reg, fxg - ONE_G, fyg - ONE_G);

    // product scaled back to the fraction format (arithmetic shift is floor)
    logic signed [2*MW-1:0] p_shift;
    logic signed [MW-1:0]   p_fx;
    assign p_shift = prod_reg >>> FRAC_BITS;
    assign p_fx    = p_shift[MW-1:0];

    logic signed [MW-1:0] mul_a, mul_b, lsum;
    assign lsum = (step_reg == 4'd9) ? MW'(g00) + p_fx
                : (step_reg == 4'd10) ? MW'(g01) + p_fx : MW'(l0_reg) + p_fx;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:    begin mul_a = tx_m;   mul_b = FIFTEEN_ONE - SIX * tx_m; end
            4'd1:    begin mul_a = tx_m;   mul_b = tx_m;                     end
            4'd2:    begin mul_a = p_fx;   mul_b = tx_m;                     end
            4'd3:    begin mul_a = p_fx;   mul_b = rx_reg;                   end
            4'd4:    begin mul_a = ty_m;   mul_b = FIFTEEN_ONE - SIX * ty_m; end
            4'd5:    begin mul_a = ty_m;   mul_b = ty_m;                     end
            4'd6:    begin mul_a = p_fx;   mul_b = ty_m;                     end
            4'd7:    begin mul_a = p_fx;   mul_b = ry_reg;                   end
            4'd8:    begin mul_a = fu_reg; mul_b = MW'(g10) - MW'(g00);      end
            4'd9:    begin mul_a = fu_reg; mul_b = MW'(g11) - MW'(g01);      end
            4'd10:   begin mul_a = fv_reg; mul_b = lsum - MW'(l0_reg);       end
            default: begin mul_a = '0;     mul_b = '0;                       end
        endcase
    end

    // normalisation: num = S + N*one, divided by 2N
    logic [OW-1:0]        oct_eff;
    logic signed [SW-1:0] n_val, num;
    assign oct_eff = (oct_cfg_reg == '0) ? OW'(1)
                   : (32'(oct_cfg_reg) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(oct_cfg_reg);
    assign n_val   = (SW'(1) <<< oct_reg) - SW'(1);
    assign num     = sum_reg + (n_val <<< FRAC_BITS);

    // ---------------------------------------------------------------- memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = bi_reg;
                mem_wdata = bi_reg;
            end
            ST_SW0:  mem_raddr = bi_reg;
            ST_SW1, ST_SW2: mem_raddr = rem_reg[IW-1:0];
            ST_SW3:
            begin
                mem_we    = 1'b1;
                mem_waddr = bi_reg;
                mem_wdata = rdata_reg;
            end
            ST_SW4:
            begin
                mem_we    = 1'b1;
                mem_waddr = rem_reg[IW-1:0];
                mem_wdata = pi_reg;
            end
            ST_OCT:
            begin
                case (step_reg)
                    4'd0:    mem_raddr = cx;
                    4'd1:    mem_raddr = cx + IW'(1);
                    4'd2:    mem_raddr = pa_reg + cy;
                    4'd3:    mem_raddr = pa_reg + cy + IW'(1);
                    4'd4:    mem_raddr = pb_reg + cy;
                    4'd5:    mem_raddr = pb_reg + cy + IW'(1);
                    default: mem_raddr = '0;
                endcase
            end
            default: mem_raddr = '0;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    logic in_fire, out_fire;
    assign point.ready       = (state_reg == ST_IDLE);
    assign in_fire           = point.valid && point.ready;
    assign out_fire          = out_valid_reg && noise.ready;
    assign noise.valid       = out_valid_reg;
    assign noise.noise_value = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: if (bi_reg == LAST_IDX) state_next = ST_SHUF;
            ST_SHUF: state_next = ST_BDIV;
            ST_BDIV: if (cnt_reg == '0) state_next = ST_SW0;
            ST_SW0:  state_next = ST_SW1;
            ST_SW1:  state_next = ST_SW2;
            ST_SW2:  state_next = ST_SW3;
            ST_SW3:  state_next = ST_SW4;
            ST_SW4:  state_next = (bi_reg == IW'(1)) ? ST_IDLE : ST_SHUF;
            ST_IDLE: if (in_fire) state_next = ST_OCT;
            ST_OCT:
            begin
                if (step_reg == 4'd11 && o_reg == oct_reg - OW'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = (num <= 0) ? ST_DONE : ST_NDIV;
            ST_NDIV: if (cnt_reg == '0) state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || noise.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (wr_en && wr_index == REG_SEED)
        begin
            state_next = ST_INIT;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            oct_cfg_reg   <= 4'd4;
            shuf_reg      <= 32'd1;
            bi_reg        <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            o_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_INIT: if (bi_reg != LAST_IDX) bi_reg <= bi_reg + IW'(1);
                ST_SHUF:
                begin
                    shuf_reg <= xs3;
                    cnt_reg  <= CW'(DW);
                end
                ST_BDIV: if (cnt_reg != '0) cnt_reg <= cnt_reg - CW'(1);
                ST_NDIV: if (cnt_reg != '0) cnt_reg <= cnt_reg - CW'(1);
                ST_SW4:  bi_reg <= bi_reg - IW'(1);
                ST_IDLE:
                begin
                    step_reg <= '0;
                    o_reg    <= '0;
                end
                ST_OCT:
                begin
                    if (step_reg == 4'd11)
                    begin
                        step_reg <= '0;
                        o_reg    <= o_reg + OW'(1);
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_FIN:  cnt_reg <= CW'(DW);
                default: step_reg <= '0;
            endcase
            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || noise.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            // configuration
            if (wr_en)
            begin
                if (wr_index == REG_SEED)
                begin
                    shuf_reg <= (wr_data == 32'd0) ? 32'd1 : wr_data;
                    bi_reg   <= '0;
                end
                else
                begin
                    oct_cfg_reg <= wr_data[3:0];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SHUF:
            begin
                quo_reg <= DW'(xs3);
                rem_reg <= '0;
                den_reg <= DENW'(bi_reg) + DENW'(1);
            end
            ST_BDIV, ST_NDIV:
            begin
                if (cnt_reg != '0)
                begin
                    rem_reg <= rem_n;
                    quo_reg <= {quo_reg[DW-2:0], div_ge};
                end
            end
            ST_SW1:  pi_reg <= rdata_reg;
            ST_IDLE:
            begin
                x_reg   <= point.x_coord;
                y_reg   <= point.y_coord;
                oct_reg <= oct_eff;
                sum_reg <= '0;
            end
            ST_OCT:
            begin
                prod_reg <= mul_a * mul_b;
                case (step_reg)
                    4'd1:  begin rx_reg <= TEN_ONE - p_fx; pa_reg <= rdata_reg; end
                    4'd2:  pb_reg  <= rdata_reg;
                    4'd3:  h00_reg <= rdata_reg[2:0];
                    4'd4:  begin fu_reg <= p_fx; h01_reg <= rdata_reg[2:0]; end
                    4'd5:  begin ry_reg <= TEN_ONE - p_fx; h10_reg <= rdata_reg[2:0]; end
                    4'd6:  h11_reg <= rdata_reg[2:0];
                    4'd8:  fv_reg  <= p_fx;
                    4'd9:  l0_reg  <= lsum[GW-1:0];
                    4'd11: sum_reg <= (sum_reg <<< 1) + SW'($signed(lsum[GW-1:0]));
                    default: ;
                endcase
            end
            ST_FIN:
            begin
                quo_reg <= DW'($unsigned(num));
                rem_reg <= '0;
                den_reg <= DENW'(n_val <<< 1);
            end
            ST_DONE:
            begin
                // result register only moves once the previous result has left
                if (!out_valid_reg || noise.ready)
                begin
                    if (num <= 0)
                    begin
                        res_reg <= '0;
                    end
                    else
                    begin
                        res_reg <= (quo_reg > ONE_Q) ? ONE_Q[FRAC_BITS:0]
                                                     : quo_reg[FRAC_BITS:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- assertions
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the completion step");

    a_result_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg <= ONE_Q[FRAC_BITS:0])
        else $error("noise value above one");

    a_no_accept_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BDIV || state_reg == ST_SW3) |=> !in_fire || state_reg == ST_IDLE)
        else $error("point transaction accepted during table build");

endmodule

// File: tb/perlin_fbm_noise_2d_checker.sv
// Checker for the fBm noise block: keeps its own copy of the table and configuration,
// predicts each noise result and compares it. Depends on pfn_pkg and pfn_if.sv.
module perlin_fbm_noise_2d_checker
    import pfn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pfn_point_if        point,
    pfn_noise_if        noise,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  perm_tbl [256];
    logic [31:0] seed_cfg;
    oct_cfg_t    oct_cfg;
    logic [16:0] noise_q [$];

    assign pending = noise_q.size();

    task automatic build_perm(input logic [31:0] sd);
        logic [31:0] s;
        longint unsigned j;
        logic [7:0] tmp;
        s = (sd == 32'd0) ? 32'd1 : sd;
        for (int i = 0; i < 256; i++)
            perm_tbl[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            s = s ^ (s << 13);
            s = s ^ (s >> 17);
            s = s ^ (s << 5);
            j = longint'(s) % longint'(i + 1);
            tmp = perm_tbl[i];
            perm_tbl[i] = perm_tbl[j];
            perm_tbl[j] = tmp;
        end
    endtask

    function automatic longint fade(input longint unsigned t);
        longint unsigned m, q, r, t2, t3;
        m  = 15 * 65536 - 6 * t;
        q  = (t * m) >> 16;
        r  = 10 * 65536 - q;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        return longint'((t3 * r) >> 16);
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic longint grad(input logic [7:0] h, input longint x, input longint y);
        longint u, v, r;
        u = (h[2] == 1'b0) ? x : y;
        v = (h[2] == 1'b0) ? y : x;
        r = h[0] ? -u : u;
        r += h[1] ? -2 * v : 2 * v;
        return r;
    endfunction

    function automatic longint octave_val(input logic [63:0] ux, input logic [63:0] uy);
        logic [7:0] cx, cy;
        logic [8:0] a, b;
        longint fx, fy, u, v, g00, g10, g01, g11;
        cx = ux[23:16];
        cy = uy[23:16];
        fx = longint'(ux[15:0]);
        fy = longint'(uy[15:0]);
        u  = fade(fx);
        v  = fade(fy);
        a  = perm_tbl[cx] + cy;
        b  = perm_tbl[8'(cx + 8'd1)] + cy;
        g00 = grad(perm_tbl[a[7:0]], fx, fy);
        g10 = grad(perm_tbl[b[7:0]], fx - 65536, fy);
        g01 = grad(perm_tbl[8'(a[7:0] + 8'd1)], fx, fy - 65536);
        g11 = grad(perm_tbl[8'(b[7:0] + 8'd1)], fx - 65536, fy - 65536);
        return lerp(lerp(g00, g10, u), lerp(g01, g11, u), v);
    endfunction

    function automatic logic [16:0] calc_noise(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] xv, yv;
        int oct;
        longint s, n, num, q;
        xv  = {{32{x[31]}}, x};
        yv  = {{32{y[31]}}, y};
        oct = int'(oct_cfg);
        if (oct < 1)
            oct = 1;
        if (oct > 8)
            oct = 8;
        s = 0;
        for (int o = 0; o < oct; o++)
            s += octave_val(xv << o, yv << o) * (longint'(1) << (oct - 1 - o));
        n   = (longint'(1) << oct) - 1;
        num = s + n * 65536;
        if (num <= 0)
            q = 0;
        else
        begin
            q = num / (2 * n);
            if (q > 65536)
                q = 65536;
        end
        return q[16:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_cfg = 32'd1;
            oct_cfg  = 4'd4;
            build_perm(seed_cfg);
            noise_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_SEED)
                begin
                    seed_cfg = wr_data;
                    build_perm(seed_cfg);
                end
                else
                    oct_cfg = wr_data[3:0];
            end
            if (point.valid && point.ready)
                noise_q.push_back(calc_noise(point.x_coord, point.y_coord));
            if (noise.valid && noise.ready)
            begin
                if (noise_q.size() == 0)
                begin
                    $display("%0t: unexpected noise result %0d", $time, noise.noise_value);
                    fail_count++;
                end
                else
                begin
                    logic [16:0] want;
                    want = noise_q.pop_front();
                    if (noise.noise_value !== want)
                    begin
                        $display("%0t: noise_value mismatch: expected %0d, got %0d",
                                 $time, want, noise.noise_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    final
    begin
    end

endmodule

// File: tb/perlin_fbm_noise_2d_tb.sv
// Testbench top for the fBm noise block: clock, reset, stimulus and verdict.
// Depends on pfn_pkg, pfn_if.sv, perlin_fbm_noise_2d and perlin_fbm_noise_2d_checker.
module perlin_fbm_noise_2d_tb;
    import pfn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic        wr_index = 1'b0;
    logic [31:0] wr_data = 32'd0;

    int fail_count;
    int pending;
    int send_idle = 0;   // percent of cycles the sender leaves a gap
    int recv_idle = 0;   // percent of cycles the receiver is not ready
    bit hold_req = 1'b0; // asks the receiver for one long hold-off
    int cycle_cnt = 0;

    pfn_point_if point_ch ();
    pfn_noise_if noise_ch ();

    initial
    begin
        point_ch.valid   = 1'b0;
        point_ch.x_coord = '0;
        point_ch.y_coord = '0;
        noise_ch.ready   = 1'b0;
    end

    always #1 clk = ~clk;

    perlin_fbm_noise_2d u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point_ch),
        .noise    (noise_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    perlin_fbm_noise_2d_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point_ch),
        .noise      (noise_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: reports FAILURE and stops a run that hangs, with room left for the
    // table rebuild after each seed write.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request so that the
    // block fills and drops point.ready while the sender keeps offering.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                noise_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            noise_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one point and return at the edge where the transaction is taken.
    // ready only moves on a rising edge, so its value at the falling edge holds
    // for the next rising one.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y);
        bit rdy;
        while ($urandom_range(99) < send_idle)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.x_coord <= x;
        point_ch.y_coord <= y;
        do
        begin
            @(negedge clk);
            rdy = point_ch.ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    // Wait until every result is back, then let the block settle.
    task automatic drain();
        point_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        drain();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // Coordinates: half full-range, some near the origin, some on cell edges.
    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom;
        else if (sel < 8)
            return 32'($signed($urandom_range(2_097_151)) - 1_048_576);
        else
            return {$urandom_range(65535) > 0 ? 16'($urandom) : 16'hFFFF,
                    $urandom_range(1) ? 16'hFFFF : 16'h0000};
    endfunction

    function automatic logic [3:0] rand_octaves();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 4'($urandom_range(4, 1));
        else if (sel < 9)
            return 4'($urandom_range(8, 5));
        else
            return $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
    endfunction

    initial
    begin
        logic [31:0] edge_vals [8];
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                      32'h0000_FFFF, 32'h00FF_0000, 32'h0100_0000, 32'h0000_8000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default settings first, then field extremes.
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_FFFF, 32'hFFFF_0001);
        send_point(32'h00FF_8000, 32'h00FF_FFFF);

        // Octave count zero is one octave, above eight is eight.
        write_reg(REG_OCTAVES, 32'd0);
        send_point(32'h0001_8000, 32'h0002_4000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        write_reg(REG_OCTAVES, 32'd15);
        send_point(32'h0001_8000, 32'h0002_4000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(REG_OCTAVES, 32'd8);
        send_point(32'h1234_5678, 32'h9ABC_DEF0);
        write_reg(REG_OCTAVES, 32'd1);
        send_point(32'h0000_8000, 32'h0000_8000);

        // A zero seed behaves as one; all-ones seed as the other extreme.
        write_reg(REG_SEED, 32'd0);
        send_point(32'h0003_4000, 32'h0005_C000);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_point(edge_vals[i], edge_vals[7 - i]);

        // Random phases: receiver-heavy idling, sender-heavy idling, none.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 19 : (ph == 1) ? 79 : 0;
            recv_idle = (ph == 0) ? 79 : (ph == 1) ? 19 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                write_reg(REG_OCTAVES, 32'(rand_octaves()));
                if (blk % 2 == 0)
                    write_reg(REG_SEED, $urandom);
                if (ph == 2 && blk == 1)
                    hold_req = 1'b1;
                for (int n = 0; n < 162; n++)
                begin
                    send_point(rand_coord(), rand_coord());
                    // Occasional pause until the pipe is empty.
                    if (n == 80 && blk == 0)
                        drain();
                end
            end
        end

        point_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (200) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: perlin_fbm_noise_2d.f
hdl/pfn_pkg.sv
hdl/pfn_if.sv
hdl/perlin_fbm_noise_2d.sv
tb/perlin_fbm_noise_2d_checker.sv
tb/perlin_fbm_noise_2d_tb.sv
